[rtl/acd_pkg.sv]
package acd_pkg;

  // Field widths.
  localparam int unsigned IDENT_W = 30;
  localparam int unsigned DEC_W   = 8;
  localparam int unsigned DATA_W  = 27;
  localparam int unsigned PREC_W  = 4;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NDIGITS = 8;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;

  // Largest data part plus one: eight decimal digits.
  localparam logic [DATA_W-1:0] DATA_LIMIT = 27'd100000000;

  // Reciprocal constants for the constant dividers.
  // n / 10 = (n * RECIP10) >> 35 for any 32-bit n.
  localparam logic [31:0]       RECIP10      = 32'hCCCCCCCD;
  localparam int unsigned       RECIP10_SH   = 35;
  // n / 10000 = (n * RECIP10K) >> 40 for n below 100000000.
  localparam logic [DATA_W-1:0] RECIP10K     = 27'd109951163;
  localparam int unsigned       RECIP10K_SH  = 40;
  // n / 100 = (n * RECIP100) >> 20 for n below 10000.
  localparam logic [13:0]       RECIP100     = 14'd10486;
  localparam int unsigned       RECIP100_SH  = 20;

  // Register levels inside the digit splitter.
  localparam int unsigned DIGIT_LAT = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DATA    = 3'd0,
    REG_MAX_DATA    = 3'd1,
    REG_MAX_DEC     = 3'd2,
    REG_NATIVE_ID   = 3'd3,
    REG_DOLLAR_ID   = 3'd4,
    REG_VESTING_ID  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_BAD_CHECK = 2'd2,
    ST_BAD_DEC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SP_ORDINARY = 2'd0,
    SP_NATIVE   = 2'd1,
    SP_DOLLAR   = 2'd2,
    SP_VESTING  = 2'd3
  } special_e;

  // Per-item results known before the check digit is computed.
  typedef struct packed {
    logic                 range_bad;
    logic [DIGIT_W-1:0]   check;
    special_e             special;
    logic                 dec_good;
    logic [NUM_W-1:0]     number;
  } side_t;

  // Damm quasigroup, row = interim digit, column = next digit.
  localparam logic [DIGIT_W-1:0] DAMM_TAB [100] = '{
    4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2,
    4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3,
    4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9,
    4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6,
    4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8,
    4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1,
    4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4,
    4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7,
    4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5,
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0
  };

  // One step of the Damm recurrence.
  function automatic logic [DIGIT_W-1:0] damm_step(input logic [DIGIT_W-1:0] s,
                                                   input logic [DIGIT_W-1:0] d);
    logic [6:0] idx;
    begin
      idx = 7'(s) * 7'd10 + 7'(d);
      return DAMM_TAB[idx];
    end
  endfunction

endpackage

[rtl/asset_id_check_digit_decoder.sv]
// Channel   Dir  Beat fields (tdata, lowest bit first)
// s_axis    in   identifier[29:0], decimals[37:30], zero pad[39:38]
// m_axis    out  asset_number[31:0], special_index[33:32], computed_check[37:34],
//                status[39:38]
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i; one register per write, no wait
//
// One beat is accepted per cycle while m_axis is not stalled. The nine register levels are
// the input register, the divide-by-ten register, the digit splitter's six levels and the
// output register.
// Reset clears every valid bit and loads the register defaults; s_axis_tready is low
// while reset is asserted.
// A stalled output freezes the whole pipeline; s_axis_tready follows it.
module asset_id_check_digit_decoder #(
  parameter logic [3:0] NATIVE_PRECISION  = 4'd3,
  parameter logic [3:0] DOLLAR_PRECISION  = 4'd3,
  parameter logic [3:0] VESTING_PRECISION = 4'd6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // identifier [29:0], decimals [37:30], zero pad [39:38]
  input  logic [39:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // asset_number [31:0], special_index [33:32], computed_check [37:34],
  // status [39:38]
  output logic [39:0]                       m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [acd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import acd_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] min_data_q;
  logic [DATA_W-1:0] max_data_q;
  logic [PREC_W-1:0] max_dec_q;
  logic [DATA_W-1:0] native_id_q;
  logic [DATA_W-1:0] dollar_id_q;
  logic [DATA_W-1:0] vesting_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_data_q   <= 27'd1;
      max_data_q   <= 27'd99999999;
      max_dec_q    <= 4'd12;
      native_id_q  <= 27'd2;
      dollar_id_q  <= 27'd1;
      vesting_id_q <= 27'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MIN_DATA:   min_data_q   <= cfg_wdata_i;
        REG_MAX_DATA:   max_data_q   <= cfg_wdata_i;
        REG_MAX_DEC:    max_dec_q    <= cfg_wdata_i[PREC_W-1:0];
        REG_NATIVE_ID:  native_id_q  <= cfg_wdata_i;
        REG_DOLLAR_ID:  dollar_id_q  <= cfg_wdata_i;
        REG_VESTING_ID: vesting_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  logic out_vld_q;
  logic en;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && rst_ni;

  // Stage 1: input register and divide by ten.
  logic               v1_q;
  logic [IDENT_W-1:0] ident1_q;
  logic [DEC_W-1:0]   dec1_q;
  logic [61:0]        prod_div10;
  logic [DATA_W-1:0]  data1;

  assign prod_div10 = 62'(ident1_q) * 62'(RECIP10);
  assign data1      = prod_div10[RECIP10_SH +: DATA_W];

  // Stage 2: check digit, range, special match and decimal checks.
  logic               v2_q;
  logic [DATA_W-1:0]  data2_q;
  logic [3:0]         ident_lo2_q;
  logic [DEC_W-1:0]   dec2_q;
  logic [3:0]         data_x10_lo;
  logic               data_big;
  logic [DATA_W-1:0]  low8;
  side_t              side2;

  assign data_x10_lo = {data2_q[0], 3'b000} + {data2_q[2:0], 1'b0};
  assign data_big    = data2_q >= DATA_LIMIT;
  assign low8        = data_big ? data2_q - DATA_LIMIT : data2_q;

  always_comb begin
    side2.range_bad = data_big || (data2_q < min_data_q) || (data2_q > max_data_q);
    side2.check     = ident_lo2_q - data_x10_lo;
    side2.number    = {data2_q, 1'b1, dec2_q[3:0]};
    if (data2_q == native_id_q) begin
      side2.special  = SP_NATIVE;
      side2.dec_good = dec2_q == DEC_W'(NATIVE_PRECISION);
    end else if (data2_q == dollar_id_q) begin
      side2.special  = SP_DOLLAR;
      side2.dec_good = dec2_q == DEC_W'(DOLLAR_PRECISION);
    end else if (data2_q == vesting_id_q) begin
      side2.special  = SP_VESTING;
      side2.dec_good = dec2_q == DEC_W'(VESTING_PRECISION);
    end else begin
      side2.special  = SP_ORDINARY;
      side2.dec_good = dec2_q <= DEC_W'(max_dec_q);
    end
  end

  // Digit split of the data part, with the side results delayed to match.
  logic [NDIGITS-1:0][DIGIT_W-1:0] digits;
  logic [DIGIT_W-1:0]              computed;
  logic                            vd_q   [DIGIT_LAT];
  side_t                           side_q [DIGIT_LAT];

  acd_digits u_digits (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (low8),
    .digits_o (digits)
  );

  acd_damm u_damm (
    .digits_i (digits),
    .check_o  (computed)
  );

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIGIT_LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      vd_q[0]   <= v2_q;
      for (int i = 1; i < DIGIT_LAT; i++) vd_q[i] <= vd_q[i-1];
      out_vld_q <= vd_q[DIGIT_LAT-1];
    end
  end

  // Final decision, range first, then check digit, then decimals.
  side_t              side_last;
  logic [NUM_W-1:0]   number_d;
  special_e           special_d;
  status_e            status_d;

  assign side_last = side_q[DIGIT_LAT-1];

  always_comb begin
    number_d  = '0;
    special_d = SP_ORDINARY;
    if (side_last.range_bad) begin
      status_d = ST_RANGE;
    end else if (side_last.check != computed) begin
      status_d = ST_BAD_CHECK;
    end else begin
      special_d = side_last.special;
      status_d  = side_last.dec_good ? ST_OK : ST_BAD_DEC;
      if (side_last.dec_good && side_last.special == SP_ORDINARY) begin
        number_d = side_last.number;
      end
    end
  end

  // Payload registers.
  logic [NUM_W-1:0]   number_q;
  special_e           special_q;
  logic [DIGIT_W-1:0] computed_q;
  status_e            status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ident1_q    <= s_axis_tdata[IDENT_W-1:0];
      dec1_q      <= s_axis_tdata[IDENT_W +: DEC_W];
      data2_q     <= data1;
      ident_lo2_q <= ident1_q[3:0];
      dec2_q      <= dec1_q;
      side_q[0]   <= side2;
      for (int i = 1; i < DIGIT_LAT; i++) side_q[i] <= side_q[i-1];
      number_q    <= number_d;
      special_q   <= special_d;
      computed_q  <= computed;
      status_q    <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {status_q, computed_q, special_q, number_q};

endmodule

[rtl/acd_digits.sv]
module acd_digits (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [acd_pkg::DATA_W-1:0]                  x_i,
  output logic [acd_pkg::NDIGITS-1:0][acd_pkg::DIGIT_W-1:0] digits_o
);
  import acd_pkg::*;

  // Level 1: split the eight-digit value into two four-digit halves.
  logic [DATA_W-1:0] x1_q;
  logic [53:0]       prod_hi;
  logic [13:0]       hi1;

  // Level 2: remainder half and hundreds of the upper half.
  logic [DATA_W-1:0] x2_q;
  logic [13:0]       hi2_q;
  logic [DATA_W-1:0] hi_x10k;
  logic [13:0]       lo2;
  logic [27:0]       prod_hh;
  logic [6:0]        hh2;

  // Level 3: low pair of the upper half and hundreds of the lower half.
  logic [13:0]       hi3_q;
  logic [13:0]       lo3_q;
  logic [6:0]        hh3_q;
  logic [13:0]       hh_x100;
  logic [6:0]        hl3;
  logic [27:0]       prod_lh;
  logic [6:0]        lh3;

  // Level 4: low pair of the lower half.
  logic [6:0]        hh4_q;
  logic [6:0]        hl4_q;
  logic [13:0]       lo4_q;
  logic [6:0]        lh4_q;
  logic [13:0]       lh_x100;
  logic [6:0]        ll4;

  // Level 5: pairs of digits, most significant pair first.
  logic [3:0][6:0]   pair5_q;
  logic [NDIGITS-1:0][DIGIT_W-1:0] dig5;

  // Level 6: single digits.
  logic [NDIGITS-1:0][DIGIT_W-1:0] dig6_q;

  assign prod_hi = 54'(x1_q) * 54'(RECIP10K);
  assign hi1     = prod_hi[RECIP10K_SH +: 14];

  assign hi_x10k = DATA_W'(hi2_q) * 27'd10000;
  assign lo2     = 14'(x2_q - hi_x10k);
  assign prod_hh = 28'(hi2_q) * 28'(RECIP100);
  assign hh2     = prod_hh[RECIP100_SH +: 7];

  assign hh_x100 = 14'(hh3_q) * 14'd100;
  assign hl3     = 7'(hi3_q - hh_x100);
  assign prod_lh = 28'(lo3_q) * 28'(RECIP100);
  assign lh3     = prod_lh[RECIP100_SH +: 7];

  assign lh_x100 = 14'(lh4_q) * 14'd100;
  assign ll4     = 7'(lo4_q - lh_x100);

  // Each pair below 100 splits into tens and units by a small reciprocal.
  always_comb begin
    logic [14:0] t_prod;
    logic [3:0]  tens;
    logic [6:0]  t_x10;
    for (int p = 0; p < 4; p++) begin
      t_prod          = 15'(pair5_q[p]) * 15'd205;
      tens            = t_prod[14:11];
      t_x10           = 7'(tens) * 7'd10;
      dig5[2*p+1]     = tens;
      dig5[2*p]       = 4'(pair5_q[p] - t_x10);
    end
  end

  // All levels move together with the pipeline enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q       <= x_i;
      x2_q       <= x1_q;
      hi2_q      <= hi1;
      hi3_q      <= hi2_q;
      lo3_q      <= lo2;
      hh3_q      <= hh2;
      hh4_q      <= hh3_q;
      hl4_q      <= hl3;
      lo4_q      <= lo3_q;
      lh4_q      <= lh3;
      pair5_q[3] <= hh4_q;
      pair5_q[2] <= hl4_q;
      pair5_q[1] <= lh4_q;
      pair5_q[0] <= ll4;
      dig6_q     <= dig5;
    end
  end

  assign digits_o = dig6_q;

endmodule

[rtl/acd_damm.sv]
module acd_damm (
  input  logic [acd_pkg::NDIGITS-1:0][acd_pkg::DIGIT_W-1:0] digits_i,
  output logic [acd_pkg::DIGIT_W-1:0]                       check_o
);
  import acd_pkg::*;

  // Run the quasigroup over the digits, most significant first, from zero.
  always_comb begin
    logic [DIGIT_W-1:0] interim;
    interim = '0;
    for (int i = NDIGITS - 1; i >= 0; i--) begin
      interim = damm_step(interim, digits_i[i]);
    end
    check_o = interim;
  end

endmodule

[rtl/acd_checker.sv]
module acd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import acd_pkg::*;

  logic [NUM_W-1:0] number;
  logic [1:0]       special;
  logic [3:0]       computed;
  logic [1:0]       status;

  assign number   = m_axis_tdata[31:0];
  assign special  = m_axis_tdata[33:32];
  assign computed = m_axis_tdata[37:34];
  assign status   = m_axis_tdata[39:38];

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A failed identifier never carries a packed asset number.
  a_fail_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ST_OK |-> number == '0)
    else $error("asset number set on a failed identifier");

  // Range and check failures report no special asset.
  a_fail_no_special: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_RANGE || status == ST_BAD_CHECK) |-> special == '0)
    else $error("special index set on a range or check failure");

  // A good ordinary asset carries the flag bit; a good special asset has no number.
  a_ok_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_OK |-> (special == '0) == number[4])
    else $error("flag bit does not match the asset kind");

  // The computed check is always a decimal digit.
  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> computed <= 4'd9)
    else $error("computed check digit out of range");

endmodule

bind asset_id_check_digit_decoder acd_checker u_acd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/asset_id_check_digit_decoder_tb.sv]
`timescale 1ns / 100ps

module asset_id_check_digit_decoder_tb;

  import acd_pkg::*;

  // Fixed precisions of the special assets, passed to the block as well.
  localparam logic [3:0] NATIVE_PREC  = 4'd3;
  localparam logic [3:0] DOLLAR_PREC  = 4'd3;
  localparam logic [3:0] VESTING_PREC = 4'd6;

  localparam int unsigned DATA_SPAN  = 100000000;
  localparam int unsigned DATA_TOP   = 99999999;
  localparam int unsigned ASSET_FLAG = 32'h10;
  localparam int unsigned DATA_SHIFT = 5;
  localparam int unsigned MASK27     = 32'h7FFFFFF;
  localparam int unsigned IDENT_MAX  = 32'h3FFFFFFF;

  // Register indexes that name no register.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned END_WAIT_MAX = 200000;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_BEATS  = 230;

  // Damm quasigroup: row is the interim digit, column the next digit.
  localparam int unsigned QUASI_TABLE [100] = '{
    0, 3, 1, 7, 5, 9, 8, 6, 4, 2,
    7, 0, 9, 2, 1, 5, 4, 8, 6, 3,
    4, 2, 0, 6, 8, 7, 1, 3, 5, 9,
    1, 7, 5, 0, 9, 8, 3, 4, 2, 6,
    6, 1, 2, 3, 0, 4, 5, 9, 7, 8,
    3, 6, 7, 4, 2, 0, 9, 5, 8, 1,
    5, 8, 6, 9, 7, 2, 0, 1, 3, 4,
    8, 9, 4, 5, 3, 6, 2, 0, 1, 7,
    9, 4, 3, 8, 6, 1, 7, 2, 0, 5,
    2, 5, 8, 1, 4, 3, 6, 7, 9, 0
  };

  // One decoded result, laid out as the output tdata from the top bit down.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  computed_check;
    logic [1:0]  special_index;
    logic [31:0] asset_number;
  } decode_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow copy of the configuration registers.
  int unsigned min_data;
  int unsigned max_data;
  int unsigned max_dec;
  int unsigned native_data;
  int unsigned dollar_data;
  int unsigned vesting_data;

  decode_t     decode_q[$];
  int unsigned fail_count;
  bit          idle_en;

  asset_id_check_digit_decoder #(
    .NATIVE_PRECISION (NATIVE_PREC),
    .DOLLAR_PRECISION (DOLLAR_PREC),
    .VESTING_PRECISION(VESTING_PREC)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Damm digit over eight decimal digits, most significant first.
  function automatic int unsigned damm_digit(input int unsigned value);
    int unsigned digits[8];
    int unsigned interim;
    int unsigned v;
    v = value % DATA_SPAN;
    interim = 0;
    for (int i = 7; i >= 0; i--) begin
      digits[i] = v % 10;
      v = v / 10;
    end
    for (int i = 0; i < 8; i++) begin
      interim = QUASI_TABLE[interim * 10 + digits[i]];
    end
    return interim;
  endfunction

  // Expected decode of one identifier under the current configuration.
  function automatic decode_t decode_asset(input logic [29:0] ident, input logic [7:0] dec);
    decode_t     r;
    int unsigned id;
    int unsigned data;
    int unsigned check;
    bit          good;
    id    = ident;
    data  = id / 10;
    check = id % 10;
    r.asset_number   = '0;
    r.special_index  = SP_ORDINARY;
    r.computed_check = 4'(damm_digit(data));
    if (data >= DATA_SPAN || data < min_data || data > max_data) begin
      r.status = ST_RANGE;
    end else if (check != r.computed_check) begin
      r.status = ST_BAD_CHECK;
    end else begin
      // Native outranks dollar, dollar outranks vesting.
      if (data == native_data) begin
        r.special_index = SP_NATIVE;
        good = (dec == NATIVE_PREC);
      end else if (data == dollar_data) begin
        r.special_index = SP_DOLLAR;
        good = (dec == DOLLAR_PREC);
      end else if (data == vesting_data) begin
        r.special_index = SP_VESTING;
        good = (dec == VESTING_PREC);
      end else begin
        good = (dec <= max_dec);
        if (good) begin
          r.asset_number = (data << DATA_SHIFT) | ASSET_FLAG | dec[3:0];
        end
      end
      r.status = good ? ST_OK : ST_BAD_DEC;
    end
    return r;
  endfunction

  // Identifier with its correct check digit, or with a wrong one.
  function automatic logic [29:0] make_ident(input int unsigned data, input bit corrupt);
    int unsigned check;
    check = damm_digit(data);
    if (corrupt) begin
      check = (check + $urandom_range(1, 9)) % 10;
    end
    return 30'(data * 10 + check);
  endfunction

  // Gap length: mostly short, a few long.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (!idle_en || $urandom_range(0, 99) < 60) begin
      return 0;
    end
    return idle_len();
  endfunction

  // Data part aimed at the interesting points of the configured range.
  function automatic int unsigned pick_data();
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    lo = min_data;
    hi = (max_data > DATA_TOP) ? DATA_TOP : max_data;
    r  = $urandom_range(0, 99);
    if (r < 8) begin
      return native_data;
    end else if (r < 16) begin
      return dollar_data;
    end else if (r < 24) begin
      return vesting_data;
    end else if (hi < lo || lo > DATA_TOP) begin
      return $urandom_range(0, DATA_TOP);
    end else if (r < 32) begin
      return lo;
    end else if (r < 40) begin
      return hi;
    end else if (r < 44) begin
      return (lo > 0) ? lo - 1 : hi + 1;
    end else if (r < 48) begin
      return hi + 1;
    end
    return $urandom_range(lo, hi);
  endfunction

  // Decimals: the fixed precision for specials most of the time, else spread.
  function automatic logic [7:0] pick_dec(input int unsigned data);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if (data == native_data) return 8'(NATIVE_PREC);
      if (data == dollar_data) return 8'(DOLLAR_PREC);
      if (data == vesting_data) return 8'(VESTING_PREC);
    end
    if (r < 75) begin
      return 8'($urandom_range(0, max_dec));
    end else if (r < 92) begin
      return 8'($urandom_range(0, 15));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Output ready: random stalls while idling is on.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted input beat queues its expected decode.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decode_q.push_back(decode_asset(s_axis_tdata[29:0], s_axis_tdata[37:30]));
    end
  end

  // Every accepted output beat is compared with the oldest expected decode.
  always @(posedge clk_i) begin
    decode_t want;
    decode_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (decode_q.size() == 0) begin
        $error("output beat with no decode pending: tdata=%h", m_axis_tdata);
        fail_count++;
      end else begin
        want = decode_q.pop_front();
        if (got.asset_number !== want.asset_number) begin
          $error("asset_number: expected %0d, actual %0d", want.asset_number, got.asset_number);
          fail_count++;
        end
        if (got.special_index !== want.special_index) begin
          $error("special_index: expected %0d, actual %0d",
                 want.special_index, got.special_index);
          fail_count++;
        end
        if (got.computed_check !== want.computed_check) begin
          $error("computed_check: expected %0d, actual %0d",
                 want.computed_check, got.computed_check);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
      end
    end
  end

  // Send one beat; returns at the edge where it is accepted.
  task automatic send_beat(input logic [29:0] ident, input logic [7:0] dec);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, dec, ident};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every pending decode has come out.
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_MIN_DATA:   min_data     = value & MASK27;
      REG_MAX_DATA:   max_data     = value & MASK27;
      REG_MAX_DEC:    max_dec      = value & 32'hF;
      REG_NATIVE_ID:  native_data  = value & MASK27;
      REG_DOLLAR_ID:  dollar_data  = value & MASK27;
      REG_VESTING_ID: vesting_data = value & MASK27;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_defaults();
    write_reg(REG_MIN_DATA, 1);
    write_reg(REG_MAX_DATA, DATA_TOP);
    write_reg(REG_MAX_DEC, 12);
    write_reg(REG_NATIVE_ID, 2);
    write_reg(REG_DOLLAR_ID, 1);
    write_reg(REG_VESTING_ID, 3);
  endtask

  // Reset values: each special asset, decimal limits, range edges, bad checks.
  task automatic test_reset_defaults();
    send_beat(30'd0, 8'd0);
    send_beat(make_ident(1, 0), 8'd3);
    send_beat(make_ident(2, 0), 8'd3);
    send_beat(make_ident(2, 0), 8'd4);
    send_beat(make_ident(3, 0), 8'd6);
    send_beat(make_ident(3, 0), 8'd3);
    send_beat(make_ident(2, 1), 8'd3);
    send_beat(make_ident(DATA_TOP, 0), 8'd12);
    send_beat(make_ident(DATA_TOP, 0), 8'd13);
    send_beat(make_ident(DATA_TOP, 0), 8'd255);
    send_beat(make_ident(DATA_TOP, 1), 8'd0);
    send_beat(make_ident(12345678, 0), 8'd0);
    send_beat(30'd999999999, 8'd7);
    send_beat(30'd1000000000, 8'd0);
    send_beat(30'(IDENT_MAX), 8'd255);
    quiesce();
  endtask

  // Equal special ids: the first match in native, dollar, vesting order wins.
  task automatic test_special_priority();
    write_reg(REG_NATIVE_ID, 777);
    write_reg(REG_DOLLAR_ID, 777);
    write_reg(REG_VESTING_ID, 777);
    send_beat(make_ident(777, 0), 8'd3);
    send_beat(make_ident(777, 0), 8'd6);
    quiesce();
    write_reg(REG_NATIVE_ID, 5);
    send_beat(make_ident(777, 0), 8'd3);
    send_beat(make_ident(777, 0), 8'd6);
    quiesce();
    load_defaults();
  endtask

  // Register extremes, masked high bits and writes to unused indexes.
  task automatic test_register_extremes();
    write_reg(REG_MIN_DATA, 0);
    write_reg(REG_MAX_DATA, 0);
    write_reg(REG_MAX_DEC, 32'h7FFFFF0);
    send_beat(make_ident(0, 0), 8'd0);
    send_beat(make_ident(0, 0), 8'd1);
    send_beat(make_ident(1, 0), 8'd3);
    quiesce();
    write_reg(REG_MIN_DATA, DATA_TOP);
    write_reg(REG_MAX_DATA, MASK27);
    write_reg(REG_MAX_DEC, MASK27);
    write_reg(REG_SPARE_6, 12345);
    write_reg(REG_SPARE_7, MASK27);
    send_beat(make_ident(DATA_TOP, 0), 8'd15);
    send_beat(30'd1000000000, 8'd15);
    send_beat(30'(IDENT_MAX), 8'd0);
    quiesce();
    write_reg(REG_MIN_DATA, MASK27);
    send_beat(make_ident(DATA_TOP, 0), 8'd0);
    quiesce();
    load_defaults();
  endtask

  // Fresh random configuration, written while the block is idle.
  task automatic randomize_config();
    int unsigned lo;
    int unsigned hi;
    int unsigned top;
    int unsigned ids[3];
    case ($urandom_range(0, 4))
      0: lo = 0;
      1: lo = 1;
      2: lo = $urandom_range(0, 1000);
      3: lo = $urandom_range(0, DATA_TOP);
      default: lo = $urandom_range(0, DATA_TOP / 2);
    endcase
    case ($urandom_range(0, 3))
      0: hi = DATA_TOP;
      1: hi = (lo + $urandom_range(0, 1000) > DATA_TOP) ? DATA_TOP : lo + $urandom_range(0, 1000);
      2: hi = $urandom_range(lo, DATA_TOP);
      default: hi = MASK27;
    endcase
    top = (hi > DATA_TOP) ? DATA_TOP : hi;
    for (int i = 0; i < 3; i++) begin
      ids[i] = $urandom_range(lo, top);
    end
    // Now and then two special ids collide.
    if ($urandom_range(0, 4) == 0) begin
      ids[$urandom_range(1, 2)] = ids[0];
    end
    write_reg(REG_MIN_DATA, lo);
    write_reg(REG_MAX_DATA, hi);
    write_reg(REG_MAX_DEC, $urandom_range(0, MASK27));
    write_reg(REG_NATIVE_ID, ids[0]);
    write_reg(REG_DOLLAR_ID, ids[1]);
    write_reg(REG_VESTING_ID, ids[2]);
    if ($urandom_range(0, 1) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom_range(0, MASK27));
    end
  endtask

  // Random traffic: mostly well-formed identifiers, the rest corrupt or noise.
  task automatic test_random_traffic();
    int unsigned data;
    int unsigned r;
    for (int p = 0; p < RAND_PHASES; p++) begin
      randomize_config();
      idle_en = (p != 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p != 0 && n % 40 == 0) begin
          idle_en = ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
          data = pick_data();
          send_beat(make_ident(data, 0), pick_dec(data));
        end else if (r < 80) begin
          data = pick_data();
          send_beat(make_ident(data, 1), pick_dec(data));
        end else begin
          send_beat(30'($urandom_range(0, IDENT_MAX)), 8'($urandom_range(0, 255)));
        end
      end
      quiesce();
    end
  endtask

  // Test sequence.
  initial begin
    int unsigned waited;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    idle_en       = 1'b0;
    min_data      = 1;
    max_data      = DATA_TOP;
    max_dec       = 12;
    native_data   = 2;
    dollar_data   = 1;
    vesting_data  = 3;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    idle_en = 1'b1;
    test_special_priority();
    test_register_extremes();
    test_random_traffic();

    // Final drain.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (decode_q.size() != 0 && waited < END_WAIT_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (decode_q.size() != 0) begin
      $error("%0d expected decodes never came out", decode_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
